>>> hdl/vid_pkg.sv
// ----------------------------------------------------------------------------
// vid_pkg
// Shared types and constants for the vertex index deduplication block.
// ----------------------------------------------------------------------------
package vid_pkg;

    // Width of the id as it leaves the block
    localparam int unsigned OUT_ID_W = 12;

    // Width of the mesh epoch stamped into every table entry
    localparam int unsigned EPOCH_W = 8;

    // Hash multipliers, one per index of the triple
    localparam logic [31:0] HASH_MUL_POS = 32'h9E37_79B1;
    localparam logic [31:0] HASH_MUL_NRM = 32'h85EB_CA77;
    localparam logic [31:0] HASH_MUL_TEX = 32'hC2B2_AE3D;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LAUNCH,
        ST_HASH,
        ST_READ,
        ST_CHECK
    } t_state;

endpackage

>>> hdl/vid_ram.sv
// ----------------------------------------------------------------------------
// vid_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module vid_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/vid_hash.sv
// ----------------------------------------------------------------------------
// vid_hash
// Home slot of an index triple: multiply-xor mix, then reduce to the table
// depth (mask for a power-of-two depth, 4-bit-per-cycle remainder otherwise).
// ----------------------------------------------------------------------------
module vid_hash
    import vid_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 4096,
    parameter int unsigned INDEX_WIDTH = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [INDEX_WIDTH-1:0]         i_pos,
    input  logic [INDEX_WIDTH-1:0]         i_nrm,
    input  logic [INDEX_WIDTH-1:0]         i_tex,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_slot
);

    localparam int unsigned AW   = $clog2(TABLE_DEPTH);
    localparam bit          POW2 = ((1 << AW) == TABLE_DEPTH);

    logic [31:0] r_prod_pos;
    logic [31:0] r_prod_nrm;
    logic [31:0] r_prod_tex;
    logic        r_v1;
    logic [31:0] r_h;
    logic        r_v2;
    logic [31:0] mix;

    // Stage 1: one multiplier per index
    always_ff @(posedge i_clk) begin
        r_prod_pos <= 32'(i_pos) * HASH_MUL_POS;
        r_prod_nrm <= 32'(i_nrm) * HASH_MUL_NRM;
        r_prod_tex <= 32'(i_tex) * HASH_MUL_TEX;
    end

    // Stage 2: fold the products
    always_comb begin
        mix = r_prod_pos ^ r_prod_nrm ^ r_prod_tex;
        mix = mix ^ (mix >> 15);
    end

    always_ff @(posedge i_clk) begin
        r_h <= mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    generate
        if (POW2) begin : g_mask
            // Power-of-two depth: the remainder is the low bits
            assign o_done = r_v2;
            assign o_slot = r_h[AW-1:0];
        end else begin : g_rem
            localparam int unsigned RW    = AW + 1;
            localparam int unsigned STEP  = 4;
            localparam int unsigned STEPS = 32 / STEP;
            localparam int unsigned CW    = $clog2(STEPS);

            logic [31:0]   r_dividend;
            logic [RW-1:0] r_rem;
            logic [RW-1:0] n_rem;
            logic [CW-1:0] r_cnt;
            logic          r_busy;
            logic          r_fin;

            // Restoring remainder, four dividend bits per cycle
            always_comb begin
                n_rem = r_rem;
                for (int k = 0; k < STEP; k++) begin
                    n_rem = {n_rem[RW-2:0], r_dividend[31-k]};
                    if (n_rem >= RW'(TABLE_DEPTH)) begin
                        n_rem = n_rem - RW'(TABLE_DEPTH);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_v2) begin
                    r_dividend <= r_h;
                    r_rem      <= '0;
                    r_cnt      <= '0;
                end else if (r_busy) begin
                    r_dividend <= r_dividend << STEP;
                    r_rem      <= n_rem;
                    r_cnt      <= r_cnt + 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b0;
                end else begin
                    r_fin <= 1'b0;
                    if (r_v2) begin
                        r_busy <= 1'b1;
                    end else if (r_busy && (r_cnt == CW'(STEPS - 1))) begin
                        r_busy <= 1'b0;
                        r_fin  <= 1'b1;
                    end
                end
            end

            assign o_done = r_fin;
            assign o_slot = r_rem[AW-1:0];
        end
    endgenerate

endmodule

>>> hdl/vertex_index_deduplication.sv
// ----------------------------------------------------------------------------
// vertex_index_deduplication
// Maps face-corner index triples to dense vertex ids through a hashed table
// with linear probing, held in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                          Transfer
//  --------  ---------------------------------------------  ------------------
//  command   i_start_mesh, i_position_index,                start & !busy
//            i_normal_index, i_texcoord_index
//  result    o_combined_index, o_is_new, o_table_full       o_valid, one cycle
//
//  An item passes from transfer through the hash and one or more probes to the
//  result strobe; each probe is one memory read and one compare.
//  A table depth that is not a power of two adds a serial remainder step.
//  After reset the block is busy while it sweeps the memory; a mesh start
//  on every 256th mesh repeats that sweep (epoch wrap).
//  The result strobe is never held off; the next item may be taken in the
//  cycle the result is shown.
// ----------------------------------------------------------------------------
module vertex_index_deduplication
    import vid_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 4096,
    parameter int unsigned INDEX_WIDTH = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_start_mesh,
    input  logic [INDEX_WIDTH-1:0] i_position_index,
    input  logic [INDEX_WIDTH-1:0] i_normal_index,
    input  logic [INDEX_WIDTH-1:0] i_texcoord_index,
    output logic                   o_valid,
    output logic [OUT_ID_W-1:0]    o_combined_index,
    output logic                   o_is_new,
    output logic                   o_table_full
);

    localparam int unsigned AW     = $clog2(TABLE_DEPTH);
    localparam int unsigned ID_W   = AW;
    localparam int unsigned KEY_W  = 3 * INDEX_WIDTH;
    localparam int unsigned ID_LO  = KEY_W;
    localparam int unsigned EP_LO  = ID_LO + ID_W;
    localparam int unsigned VB     = EP_LO + EPOCH_W;
    localparam int unsigned WORD_W = VB + 1;

    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_clr_addr;
    logic                r_pending;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [ID_W:0]       r_next_id;
    logic [KEY_W-1:0]    r_key;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_probes;
    logic                r_valid;
    logic [ID_W-1:0]     r_id;
    logic                r_is_new;
    logic                r_full;

    logic                accept;
    logic                clr_last;
    logic                epoch_wrap;
    logic                hash_start;
    logic                hash_done;
    logic [AW-1:0]       hash_slot;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_W-1:0]   ram_rdata;
    logic                ent_valid;
    logic                key_hit;
    logic                last_probe;
    logic                room;
    logic                finish;
    logic [AW-1:0]       addr_next;
    logic [ID_W+OUT_ID_W-1:0] id_ext;

    assign accept     = start && !busy;
    assign clr_last   = (r_clr_addr == AW'(TABLE_DEPTH - 1));
    assign epoch_wrap = (r_epoch == {EPOCH_W{1'b1}});

    // Probe decode of the word read back
    assign ent_valid  = ram_rdata[VB] && (ram_rdata[VB-1:EP_LO] == r_epoch);
    assign key_hit    = (ram_rdata[KEY_W-1:0] == r_key);
    assign last_probe = (r_probes == AW'(TABLE_DEPTH - 1));
    assign room       = (r_next_id < (ID_W + 1)'(TABLE_DEPTH));
    assign finish     = !ent_valid || key_hit || last_probe;
    assign addr_next  = (r_addr == AW'(TABLE_DEPTH - 1)) ? '0 : r_addr + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = r_pending ? ST_LAUNCH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_start_mesh && epoch_wrap) ? ST_CLEAR : ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                n_state = ST_HASH;
            end
            ST_HASH: begin
                if (hash_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = finish ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        busy       = 1'b1;
        hash_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = {1'b1, r_epoch, r_next_id[ID_W-1:0], r_key};
        ram_re     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_LAUNCH: begin
                hash_start = 1'b1;
            end
            ST_HASH: begin
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_CHECK: begin
                ram_we = !ent_valid && room;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_pending  <= 1'b0;
            r_epoch    <= '0;
            r_next_id  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            // Sweep the memory, then start a fresh epoch
            if (r_state == ST_CLEAR) begin
                if (clr_last) begin
                    r_clr_addr <= '0;
                    r_pending  <= 1'b0;
                    r_epoch    <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            // Mesh start drops the table by moving to a new epoch, or by a fresh sweep when the epoch wraps
            if (accept && i_start_mesh) begin
                r_next_id <= '0;
                if (epoch_wrap) begin
                    r_pending <= 1'b1;
                end else begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
            if ((r_state == ST_CHECK) && finish) begin
                r_valid <= 1'b1;
                if (!ent_valid && room) begin
                    r_next_id <= r_next_id + 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= {i_texcoord_index, i_normal_index, i_position_index};
        end
        if ((r_state == ST_HASH) && hash_done) begin
            r_addr   <= hash_slot;
            r_probes <= '0;
        end
        if ((r_state == ST_CHECK) && !finish) begin
            r_addr   <= addr_next;
            r_probes <= r_probes + 1'b1;
        end
        // Resolve the item: free slot, hit, or out of room
        if ((r_state == ST_CHECK) && finish) begin
            priority if (!ent_valid && room) begin
                r_id     <= r_next_id[ID_W-1:0];
                r_is_new <= 1'b1;
                r_full   <= 1'b0;
            end else if (ent_valid && key_hit) begin
                r_id     <= ram_rdata[EP_LO-1:ID_LO];
                r_is_new <= 1'b0;
                r_full   <= 1'b0;
            end else begin
                r_id     <= '0;
                r_is_new <= 1'b0;
                r_full   <= 1'b1;
            end
        end
    end

    assign id_ext           = {{OUT_ID_W{1'b0}}, r_id};
    assign o_valid          = r_valid;
    assign o_combined_index = id_ext[OUT_ID_W-1:0];
    assign o_is_new         = r_is_new;
    assign o_table_full     = r_full;

    vid_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_pos   (r_key[INDEX_WIDTH-1:0]),
        .i_nrm   (r_key[2*INDEX_WIDTH-1:INDEX_WIDTH]),
        .i_tex   (r_key[KEY_W-1:2*INDEX_WIDTH]),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    vid_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

endmodule
